>>> hdl/pial_pkg.sv
// Shared types and constants of the port and id lease allocator.
package pial_pkg;

  localparam int ID_W   = 31;
  localparam int PORT_W = 16;
  localparam int PCNT_W = 7;
  localparam int LIVE_W = 5;

  localparam logic [PORT_W-1:0] FIRST_PORT_RST = 16'd1024;
  localparam logic [PCNT_W-1:0] PORT_COUNT_RST = 7'd1;

  typedef enum logic [1:0] {
    ACT_ACQUIRE = 2'd0,
    ACT_RELEASE = 2'd1,
    ACT_CHECK   = 2'd2,
    ACT_NONE    = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_NEW      = 3'd0,
    ST_EXIST    = 3'd1,
    ST_REFUSED  = 3'd2,
    ST_FULL     = 3'd3,
    ST_RELEASED = 3'd4,
    ST_DONE     = 3'd5
  } status_e;

  typedef enum logic [0:0] {
    REG_FIRST_PORT = 1'b0,
    REG_PORT_COUNT = 1'b1
  } reg_e;

  // Commands from the sequencer to the lease table
  typedef struct packed {
    logic issue;    // read an entry for the compare unit
    logic set_vld;  // write a new lease
    logic clr_vld;  // drop a lease
  } tab_ctl_t;

  typedef struct packed {
    logic id_hit;
    logic port_hit;
  } tab_hit_t;

endpackage

>>> hdl/pial_table.sv
// Lease table: id and offset memory, valid bits and the shared compare unit.
module pial_table
  import pial_pkg::*;
#(
  parameter int MAX_OWNERS = 16,
  parameter int POOL_PORTS = 64
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  tab_ctl_t                                     ctl_i,
  input  logic [((MAX_OWNERS > 1) ? $clog2(MAX_OWNERS) : 1)-1:0] rd_addr_i,
  input  logic [((MAX_OWNERS > 1) ? $clog2(MAX_OWNERS) : 1)-1:0] wr_addr_i,
  input  logic [ID_W-1:0]                              wr_id_i,
  input  logic [((POOL_PORTS > 1) ? $clog2(POOL_PORTS) : 1)-1:0] wr_off_i,
  input  logic [ID_W-1:0]                              tgt_id_i,
  input  logic [PORT_W-1:0]                            tgt_port_i,
  input  logic [PORT_W-1:0]                            first_port_i,
  output logic [ID_W-1:0]                              rd_id_o,
  output logic [((POOL_PORTS > 1) ? $clog2(POOL_PORTS) : 1)-1:0] rd_off_o,
  output logic [MAX_OWNERS-1:0]                        valid_o,
  output tab_hit_t                                     hit_o
);

  localparam int OWN_W = (MAX_OWNERS > 1) ? $clog2(MAX_OWNERS) : 1;
  localparam int OFF_W = (POOL_PORTS > 1) ? $clog2(POOL_PORTS) : 1;

  logic [ID_W-1:0]   id_mem  [MAX_OWNERS];
  logic [OFF_W-1:0]  off_mem [MAX_OWNERS];
  logic [ID_W-1:0]   rd_id_q;
  logic [OFF_W-1:0]  rd_off_q;
  logic [MAX_OWNERS-1:0] valid_q, valid_d;
  logic              issue_q;
  logic [OWN_W-1:0]  cmp_idx_q;
  logic [PORT_W-1:0] rd_port;

  always_ff @(posedge clk_i) begin
    if (ctl_i.set_vld) begin
      id_mem[wr_addr_i]  <= wr_id_i;
      off_mem[wr_addr_i] <= wr_off_i;
    end
    rd_id_q  <= id_mem[rd_addr_i];
    rd_off_q <= off_mem[rd_addr_i];
  end

  always_comb begin
    valid_d = valid_q;
    if (ctl_i.set_vld) valid_d[wr_addr_i] = 1'b1;
    if (ctl_i.clr_vld) valid_d[wr_addr_i] = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= '0;
      issue_q   <= 1'b0;
      cmp_idx_q <= '0;
    end else begin
      valid_q   <= valid_d;
      issue_q   <= ctl_i.issue;
      cmp_idx_q <= rd_addr_i;
    end
  end

  // Compare the entry read last cycle against the target id and port
  assign rd_port = first_port_i + PORT_W'(rd_off_q);

  assign hit_o.id_hit   = issue_q && valid_q[cmp_idx_q] && (tgt_id_i != '0)
                          && (rd_id_q == tgt_id_i);
  assign hit_o.port_hit = issue_q && valid_q[cmp_idx_q] && (rd_port == tgt_port_i);

  assign rd_id_o  = rd_id_q;
  assign rd_off_o = rd_off_q;
  assign valid_o  = valid_q;

endmodule

>>> hdl/port_and_id_lease_allocator_core.sv
// Top level of the port and session-id lease allocator.
//
// Each owner slot holds at most one lease: a nonzero 31-bit session id and
// one port taken from a pool of port_count ports starting at first_port.
// Request words enter on the in channel (in_valid_i / in_stall_o), one
// result word leaves on the out channel (out_valid_o / out_stall_i) per
// request. The pool registers sit on the APB port at byte addresses 0 and 4.
//
// One request is worked at a time; in_stall_o is high from acceptance until
// its result is loaded into the output register. A check walks the lease
// table through the single compare unit. A new acquire adds the pool scan,
// one port a cycle from the next-fit hint. A result waiting in the output
// register does not stop the next request from being worked; a stalled
// result holds and the following one waits in its final step until the
// output register frees.
// Reset clears all leases, the busy map, the hint and the live count, and
// sets first_port to 1024 and port_count to 1.
module port_and_id_lease_allocator_core
  import pial_pkg::*;
#(
  parameter int MAX_OWNERS = 16,
  parameter int POOL_PORTS = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        action_i,
  input  logic [3:0]        owner_index_i,
  input  logic [ID_W-1:0]   candidate_scid_i,
  input  logic [PORT_W-1:0] query_port_i,
  input  logic [ID_W-1:0]   query_scid_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [2:0]        status_o,
  output logic [ID_W-1:0]   lease_scid_o,
  output logic [PORT_W-1:0] lease_port_o,
  output logic              port_in_use_o,
  output logic              scid_in_use_o,
  output logic [LIVE_W-1:0] live_count_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int OWN_W = (MAX_OWNERS > 1) ? $clog2(MAX_OWNERS) : 1;
  localparam int OFF_W = (POOL_PORTS > 1) ? $clog2(POOL_PORTS) : 1;
  localparam int NW    = $clog2(POOL_PORTS + 1);
  localparam int CW    = OFF_W + 1;
  localparam int KW    = $clog2(MAX_OWNERS + 1);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DECIDE = 6'b000010,
    S_OWNRD  = 6'b000100,
    S_IDSCAN = 6'b001000,
    S_PSCAN  = 6'b010000,
    S_DONE   = 6'b100000
  } state_e;

  state_e              state_q, state_d;
  action_e             act_q;
  logic [3:0]          own_q;
  logic [ID_W-1:0]     cand_q, qid_q;
  logic [PORT_W-1:0]   qport_q;
  logic [KW-1:0]       k_q, k_d;
  logic [NW-1:0]       i_q, i_d;
  logic [OFF_W-1:0]    off_q, off_d, next_q, next_d;
  logic [KW-1:0]       total_q, total_d;
  logic [POOL_PORTS-1:0] busy_q, busy_d;
  logic [PORT_W-1:0]   first_q, first_d;
  logic [PCNT_W-1:0]   count_q, count_d;
  logic                id_hit_q, id_hit_d, port_hit_q, port_hit_d;
  status_e             res_status_q, res_status_d;
  logic [ID_W-1:0]     res_id_q, res_id_d;
  logic [PORT_W-1:0]   res_port_q, res_port_d;
  logic                res_pin_q, res_pin_d, res_sin_q, res_sin_d;
  logic                out_valid_q, out_valid_d;
  status_e             out_status_q, out_status_d;
  logic [ID_W-1:0]     out_id_q, out_id_d;
  logic [PORT_W-1:0]   out_port_q, out_port_d;
  logic                out_pin_q, out_pin_d, out_sin_q, out_sin_d;
  logic [LIVE_W-1:0]   out_live_q, out_live_d;

  logic                in_acc, cfg_wr, own_ok, own_held;
  logic [OWN_W-1:0]    own_idx, rd_addr;
  logic [NW-1:0]       pool_n;
  logic [CW-1:0]       off_inc;
  logic                off_wrap;
  logic [OFF_W-1:0]    off_next, scan_start;
  logic                id_hit_all, port_hit_all;
  tab_ctl_t            tab_ctl;
  tab_hit_t            tab_hit;
  logic [ID_W-1:0]     tab_rd_id, tgt_id;
  logic [OFF_W-1:0]    tab_rd_off;
  logic [MAX_OWNERS-1:0] lease_vld;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && (state_q == S_IDLE);
  assign cfg_wr     = psel && penable && pwrite && pready;
  assign pready     = 1'b1;
  assign prdata     = (reg_e'(paddr[2]) == REG_PORT_COUNT) ? 32'(count_q) : 32'(first_q);

  assign own_ok   = int'(own_q) < MAX_OWNERS;
  assign own_idx  = OWN_W'(own_q);
  assign own_held = own_ok && lease_vld[own_idx];

  assign pool_n = (int'(count_q) > POOL_PORTS) ? NW'(POOL_PORTS) : NW'(count_q);

  // Round-robin step through the pool
  assign off_inc    = CW'(off_q) + CW'(1);
  assign off_wrap   = (off_inc == CW'(pool_n));
  assign off_next   = off_wrap ? '0 : off_inc[OFF_W-1:0];
  assign scan_start = (CW'(next_q) < CW'(pool_n)) ? next_q : '0;

  assign tgt_id       = (act_q == ACT_CHECK) ? qid_q : cand_q;
  assign id_hit_all   = id_hit_q | tab_hit.id_hit;
  assign port_hit_all = port_hit_q | tab_hit.port_hit;

  pial_table #(
    .MAX_OWNERS (MAX_OWNERS),
    .POOL_PORTS (POOL_PORTS)
  ) u_table (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (tab_ctl),
    .rd_addr_i    (rd_addr),
    .wr_addr_i    (own_idx),
    .wr_id_i      (cand_q),
    .wr_off_i     (off_q),
    .tgt_id_i     (tgt_id),
    .tgt_port_i   (qport_q),
    .first_port_i (first_q),
    .rd_id_o      (tab_rd_id),
    .rd_off_o     (tab_rd_off),
    .valid_o      (lease_vld),
    .hit_o        (tab_hit)
  );

  always_comb begin
    state_d      = state_q;
    k_d          = k_q;
    i_d          = i_q;
    off_d        = off_q;
    next_d       = next_q;
    total_d      = total_q;
    busy_d       = busy_q;
    first_d      = first_q;
    count_d      = count_q;
    id_hit_d     = id_hit_q;
    port_hit_d   = port_hit_q;
    res_status_d = res_status_q;
    res_id_d     = res_id_q;
    res_port_d   = res_port_q;
    res_pin_d    = res_pin_q;
    res_sin_d    = res_sin_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_id_d     = out_id_q;
    out_port_d   = out_port_q;
    out_pin_d    = out_pin_q;
    out_sin_d    = out_sin_q;
    out_live_d   = out_live_q;
    tab_ctl      = '0;
    rd_addr      = own_idx;

    if (cfg_wr) begin
      unique case (reg_e'(paddr[2]))
        REG_FIRST_PORT: begin
          first_d = pwdata[PORT_W-1:0];
          next_d  = '0;
        end
        REG_PORT_COUNT: begin
          count_d = (pwdata[PCNT_W-1:0] == '0) ? PCNT_W'(1) : pwdata[PCNT_W-1:0];
          next_d  = '0;
        end
      endcase
    end

    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_DECIDE;
      end
      S_DECIDE: begin
        res_status_d = ST_DONE;
        res_id_d     = '0;
        res_port_d   = '0;
        res_pin_d    = 1'b0;
        res_sin_d    = 1'b0;
        k_d          = '0;
        id_hit_d     = 1'b0;
        port_hit_d   = 1'b0;
        state_d      = S_DONE;
        unique case (act_q)
          ACT_ACQUIRE: begin
            if (!own_ok) begin
              res_status_d = ST_FULL;
            end else if (own_held) begin
              state_d = S_OWNRD;
            end else if (cand_q == '0) begin
              res_status_d = ST_REFUSED;
            end else begin
              state_d = S_IDSCAN;
            end
          end
          ACT_RELEASE: begin
            if (own_held) state_d = S_OWNRD;
          end
          ACT_CHECK: state_d = S_IDSCAN;
          ACT_NONE:  state_d = S_DONE;
        endcase
      end
      S_OWNRD: begin
        // the owner's entry was read on the previous edge
        res_id_d   = tab_rd_id;
        res_port_d = first_q + PORT_W'(tab_rd_off);
        if (act_q == ACT_ACQUIRE) begin
          res_status_d = ST_EXIST;
        end else begin
          res_status_d = ST_RELEASED;
          tab_ctl.clr_vld = 1'b1;
          if (int'(tab_rd_off) < POOL_PORTS) busy_d[tab_rd_off] = 1'b0;
          if (total_q != '0) total_d = total_q - KW'(1);
        end
        state_d = S_DONE;
      end
      S_IDSCAN: begin
        id_hit_d   = id_hit_all;
        port_hit_d = port_hit_all;
        if (k_q != KW'(MAX_OWNERS)) begin
          tab_ctl.issue = 1'b1;
          rd_addr       = OWN_W'(k_q);
          k_d           = k_q + KW'(1);
        end else if (act_q == ACT_CHECK) begin
          res_pin_d = port_hit_all;
          res_sin_d = id_hit_all;
          state_d   = S_DONE;
        end else if (id_hit_all) begin
          res_status_d = ST_REFUSED;
          state_d      = S_DONE;
        end else begin
          off_d   = scan_start;
          i_d     = '0;
          state_d = S_PSCAN;
        end
      end
      S_PSCAN: begin
        if (!busy_q[off_q]) begin
          busy_d[off_q]   = 1'b1;
          tab_ctl.set_vld = 1'b1;
          total_d         = total_q + KW'(1);
          next_d          = off_next;
          res_status_d    = ST_NEW;
          res_id_d        = cand_q;
          res_port_d      = first_q + PORT_W'(off_q);
          state_d         = S_DONE;
        end else if (i_q == pool_n - NW'(1)) begin
          res_status_d = ST_FULL;
          state_d      = S_DONE;
        end else begin
          i_d   = i_q + NW'(1);
          off_d = off_next;
        end
      end
      S_DONE: begin
        // load the output register once it is free or being taken
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_id_d     = res_id_q;
          out_port_d   = res_port_q;
          out_pin_d    = res_pin_q;
          out_sin_d    = res_sin_q;
          out_live_d   = LIVE_W'(total_q);
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      act_q   <= action_e'(action_i);
      own_q   <= owner_index_i;
      cand_q  <= candidate_scid_i;
      qport_q <= query_port_i;
      qid_q   <= query_scid_i;
    end
    k_q          <= k_d;
    i_q          <= i_d;
    off_q        <= off_d;
    id_hit_q     <= id_hit_d;
    port_hit_q   <= port_hit_d;
    res_status_q <= res_status_d;
    res_id_q     <= res_id_d;
    res_port_q   <= res_port_d;
    res_pin_q    <= res_pin_d;
    res_sin_q    <= res_sin_d;
    out_status_q <= out_status_d;
    out_id_q     <= out_id_d;
    out_port_q   <= out_port_d;
    out_pin_q    <= out_pin_d;
    out_sin_q    <= out_sin_d;
    out_live_q   <= out_live_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      next_q      <= '0;
      total_q     <= '0;
      busy_q      <= '0;
      first_q     <= FIRST_PORT_RST;
      count_q     <= PORT_COUNT_RST;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      next_q      <= next_d;
      total_q     <= total_d;
      busy_q      <= busy_d;
      first_q     <= first_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign lease_scid_o  = out_id_q;
  assign lease_port_o  = out_port_q;
  assign port_in_use_o = out_pin_q;
  assign scid_in_use_o = out_sin_q;
  assign live_count_o  = out_live_q;

  a_total_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(total_q) <= MAX_OWNERS)
    else $error("live lease count beyond owner slots");

  a_total_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(lease_vld) == int'(total_q))
    else $error("live lease count differs from valid entries");

  a_total_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(busy_q) == int'(total_q))
    else $error("busy ports differ from live leases");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PSCAN) |-> (i_q < pool_n))
    else $error("pool scan ran past the pool size");

endmodule
